>>> rtl/utp_pkg.sv
// Shared constants, widths and glyph table for the UTF-8 text glyph placer.
`timescale 1ns / 1ps

package utp_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int GLYPH_CELL     = 8;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int CUR_W   = 8;
    localparam int LEAD_W  = 5;
    localparam int CODE_W  = 11;
    localparam int GLYPH_W = 7;
    localparam int ADDR_W  = 10;
    localparam int PAGE_SHIFT = 7;

    localparam int HI_COUNT = 23;

    // Code used for bytes that only move the cursor
    localparam logic [CODE_W-1:0] CODE_NONE = 11'h100;

    localparam logic [BYTE_W-1:0] LEAD_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_MATCH = 8'hC0;

    localparam logic [GLYPH_W-1:0] GLYPH_UPPER  = 7'd1;
    localparam logic [GLYPH_W-1:0] GLYPH_DIGIT  = 7'd27;
    localparam logic [GLYPH_W-1:0] GLYPH_LOWER  = 7'd37;
    localparam logic [GLYPH_W-1:0] GLYPH_PERIOD = 7'd63;
    localparam logic [GLYPH_W-1:0] GLYPH_COLON  = 7'd64;
    localparam logic [GLYPH_W-1:0] GLYPH_HASH   = 7'd65;
    localparam logic [GLYPH_W-1:0] GLYPH_BANG   = 7'd66;
    localparam logic [GLYPH_W-1:0] GLYPH_QUERY  = 7'd67;
    localparam logic [GLYPH_W-1:0] GLYPH_LATIN  = 7'd68;
    localparam logic [GLYPH_W-1:0] GLYPH_COMMA  = 7'd91;
    localparam logic [GLYPH_W-1:0] GLYPH_DASH   = 7'd92;
    localparam logic [GLYPH_W-1:0] GLYPH_BLANK  = 7'd0;

    // Latin-1 accented letters, in glyph order
    localparam logic [BYTE_W-1:0] HI_CODES [HI_COUNT] = '{
        8'hC3, 8'hC2, 8'hC1, 8'hC0, 8'hC9, 8'hCA, 8'hCD, 8'hD3, 8'hD4, 8'hD5,
        8'hDA, 8'hC7, 8'hE7, 8'hE3, 8'hE1, 8'hE0, 8'hE2, 8'hE9, 8'hEA, 8'hED,
        8'hF3, 8'hF4, 8'hFA
    };

endpackage

>>> rtl/utp_in_if.sv
// Input channel: one text word per handshake.
`timescale 1ns / 1ps

interface utp_in_if;
    logic                       valid;
    logic                       ready;
    logic                       string_start;
    logic [utp_pkg::COL_W-1:0]  start_col;
    logic [utp_pkg::ROW_W-1:0]  start_row;
    logic [utp_pkg::BYTE_W-1:0] text_byte;

    modport source (output valid, output string_start, output start_col,
                    output start_row, output text_byte, input ready);
    modport sink   (input valid, input string_start, input start_col,
                    input start_row, input text_byte, output ready);
endinterface

>>> rtl/utp_out_if.sv
// Output channel: one placed glyph word per handshake.
`timescale 1ns / 1ps

interface utp_out_if;
    logic                        valid;
    logic                        ready;
    logic [utp_pkg::GLYPH_W-1:0] glyph_index;
    logic [utp_pkg::ADDR_W-1:0]  frame_address;

    modport source (output valid, output glyph_index, output frame_address,
                    input ready);
    modport sink   (input valid, input glyph_index, input frame_address,
                    output ready);
endinterface

>>> rtl/utf8_text_glyph_placer.sv
// Top level of the UTF-8 text glyph placer.
`timescale 1ns / 1ps

// Usage
//   text_in  : one text byte per word. string_start=1 loads the cursor from
//              start_col/start_row and opens a new string. A zero byte,
//              or running below the last text row, closes the string; bytes
//              after that are dropped until the next string_start.
//   glyph_out: zero or one word per input word: the glyph number and the
//              framebuffer byte address (page*128 + column) of its first
//              column. Lead bytes, terminators, off-screen glyphs and
//              unsupported bytes produce no word.
// Timing
//   One input word per cycle while glyph_out keeps taking results. A result
//   appears in the cycle after its input word is taken, from the output register.
//   text_in.ready drops only while the output register holds a word that
//   glyph_out is not taking; the stalled word stays put until taken.
// Reset
//   rst_n low empties the output register, homes the cursor, drops any
//   pending lead byte and marks no string active.

module utf8_text_glyph_placer (
    input  logic     clk,
    input  logic     rst_n,
    utp_in_if.sink   text_in,
    utp_out_if.source glyph_out
);
    import utp_pkg::*;

    // cursor and decode state
    logic [CUR_W-1:0]  col_reg, col_next;
    logic [CUR_W-1:0]  row_reg, row_next;
    logic [LEAD_W-1:0] lead_reg, lead_next;
    logic              await_reg, await_next;
    logic              done_reg, done_next;

    // output register
    logic               out_valid_reg;
    logic [GLYPH_W-1:0] glyph_reg;
    logic [ADDR_W-1:0]  addr_reg;

    logic accept;

    // state after an optional string start
    logic [CUR_W-1:0]  col_s, row_s;
    logic [LEAD_W-1:0] lead_s;
    logic              await_s, done_s;

    logic [BYTE_W-1:0] b;
    logic              place;
    logic              emit;
    logic [CODE_W-1:0] code;
    logic [CUR_W:0]    col_plus, row_plus, col_adv_plus;
    logic [CUR_W-1:0]  col_adv;
    logic              fits_col, fits_row;
    logic [GLYPH_W-1:0] glyph_idx;
    logic [ADDR_W-1:0] addr_calc;

    assign text_in.ready = !out_valid_reg || glyph_out.ready;
    assign accept        = text_in.valid && text_in.ready;
    assign b             = text_in.text_byte;

    always_comb
    begin
        if (text_in.string_start)
        begin
            col_s   = CUR_W'(text_in.start_col);
            row_s   = CUR_W'(text_in.start_row);
            lead_s  = '0;
            await_s = 1'b0;
            done_s  = 1'b0;
        end
        else
        begin
            col_s   = col_reg;
            row_s   = row_reg;
            lead_s  = lead_reg;
            await_s = await_reg;
            done_s  = done_reg;
        end
    end

    assign col_plus = {1'b0, col_s} + (CUR_W+1)'(GLYPH_CELL);
    assign row_plus = {1'b0, row_s} + (CUR_W+1)'(GLYPH_CELL);
    assign fits_col = (col_plus <= (CUR_W+1)'(DISPLAY_WIDTH));
    assign fits_row = (row_plus <= (CUR_W+1)'(DISPLAY_HEIGHT));

    // cursor step; column wraps once the next cell would not fit
    assign col_adv      = col_plus[CUR_W-1:0];
    assign col_adv_plus = {1'b0, col_adv} + (CUR_W+1)'(GLYPH_CELL);

    // byte classification
    always_comb
    begin
        place      = 1'b0;
        emit       = 1'b0;
        code       = CODE_NONE;
        lead_next  = lead_s;
        await_next = await_s;
        done_next  = done_s;
        if (!done_s)
        begin
            if (await_s)
            begin
                // second byte of a pair: no row check, zero still ends
                await_next = 1'b0;
                if (b == '0)
                    done_next = 1'b1;
                else
                begin
                    place = 1'b1;
                    emit  = 1'b1;
                    code  = {lead_s, b[5:0]};
                end
            end
            else if (b == '0 || !fits_row)
                done_next = 1'b1;
            else if (!b[BYTE_W-1])
            begin
                place = 1'b1;
                emit  = 1'b1;
                code  = CODE_W'(b);
            end
            else if ((b & LEAD_MASK) == LEAD_MATCH)
            begin
                lead_next  = b[LEAD_W-1:0];
                await_next = 1'b1;
            end
            else
                place = 1'b1;   // unsupported byte only moves the cursor
        end
    end

    always_comb
    begin
        col_next = col_s;
        row_next = row_s;
        if (place)
        begin
            if (col_adv_plus > (CUR_W+1)'(DISPLAY_WIDTH))
            begin
                col_next = '0;
                row_next = row_plus[CUR_W-1:0];
            end
            else
                col_next = col_adv;
        end
    end

    utp_glyph_map u_glyph_map (
        .code        (code),
        .glyph_index (glyph_idx)
    );

    // page = row / 8, 128 bytes per page
    assign addr_calc = ADDR_W'((16'(row_s >> 3) << PAGE_SHIFT) + 16'(col_s));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            lead_reg  <= '0;
            await_reg <= 1'b0;
            done_reg  <= 1'b1;
        end
        else if (accept)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            lead_reg  <= lead_next;
            await_reg <= await_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (text_in.ready)
            out_valid_reg <= accept && emit && fits_col && fits_row;
    end

    always_ff @(posedge clk)
    begin
        if (text_in.ready)
        begin
            glyph_reg <= glyph_idx;
            addr_reg  <= addr_calc;
        end
    end

    assign glyph_out.valid         = out_valid_reg;
    assign glyph_out.glyph_index   = glyph_reg;
    assign glyph_out.frame_address = addr_reg;

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !text_in.ready |-> out_valid_reg)
        else $error("input stalled with empty output register");

    // a pending lead byte implies an open string
    a_lead_open: assert property (@(posedge clk) disable iff (!rst_n)
        await_reg |-> !done_reg)
        else $error("lead byte pending with no active string");

    // emitted glyph's column lies fully on screen
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        glyph_out.valid |->
            glyph_out.frame_address[PAGE_SHIFT-1:0] <=
                PAGE_SHIFT'(DISPLAY_WIDTH - GLYPH_CELL))
        else $error("glyph column off screen");

    // a new result comes only from a word taken the cycle before
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(accept))
        else $error("result without accepted input");

endmodule

>>> rtl/utp_glyph_map.sv
// Character code to font glyph number lookup.
`timescale 1ns / 1ps

module utp_glyph_map (
    input  logic [utp_pkg::CODE_W-1:0]  code,
    output logic [utp_pkg::GLYPH_W-1:0] glyph_index
);
    import utp_pkg::*;

    logic [BYTE_W-1:0] low_byte;
    logic              in_byte;

    assign low_byte = code[BYTE_W-1:0];
    assign in_byte  = (code[CODE_W-1:BYTE_W] == '0);

    always_comb
    begin
        glyph_index = GLYPH_BLANK;
        if (in_byte)
        begin
            if (low_byte >= 8'h41 && low_byte <= 8'h5A)
                glyph_index = GLYPH_W'(low_byte - 8'h41) + GLYPH_UPPER;
            else if (low_byte >= 8'h30 && low_byte <= 8'h39)
                glyph_index = GLYPH_W'(low_byte - 8'h30) + GLYPH_DIGIT;
            else if (low_byte >= 8'h61 && low_byte <= 8'h7A)
                glyph_index = GLYPH_W'(low_byte - 8'h61) + GLYPH_LOWER;
            else
            begin
                case (low_byte)
                    8'h2E:   glyph_index = GLYPH_PERIOD;
                    8'h3A:   glyph_index = GLYPH_COLON;
                    8'h23:   glyph_index = GLYPH_HASH;
                    8'h21:   glyph_index = GLYPH_BANG;
                    8'h3F:   glyph_index = GLYPH_QUERY;
                    8'h2C:   glyph_index = GLYPH_COMMA;
                    8'h2D:   glyph_index = GLYPH_DASH;
                    default:
                    begin
                        // table entries are distinct, so at most one hits
                        for (int k = 0; k < HI_COUNT; k++)
                        begin
                            if (HI_CODES[k] == low_byte)
                                glyph_index = GLYPH_LATIN + GLYPH_W'(k);
                        end
                    end
                endcase
            end
        end
    end

endmodule
